// ===== rtl/periodic_task_timer_table_unit_assert.svh =====
`ifndef PERIODIC_TASK_TIMER_TABLE_UNIT_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_UNIT_ASSERT_SVH

// same-cycle check, quiet during reset
`define PTTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// next-cycle check, quiet during reset
`define PTTT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/pttt_pkg.sv =====
package pttt_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int TICK_MS_DEF    = 10;

    typedef enum logic [1:0] {
        KIND_DUE   = 2'd0,
        KIND_ADDED = 2'd1,
        KIND_FULL  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]  handle;
        logic [16:0] ticks;
        logic [15:0] reload;
    } t_entry;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_A_MUL   = 7'b0000010,
        S_A_FIX   = 7'b0000100,
        S_A_SCAN  = 7'b0001000,
        S_A_EMIT  = 7'b0010000,
        S_T_EVAL  = 7'b0100000,
        S_T_FLUSH = 7'b1000000
    } t_state;

endpackage

// ===== rtl/periodic_task_timer_table_unit.sv =====
// Periodic task timer table. Up to TASK_SLOTS task timers live in one
// synchronous memory (handle, remaining ticks, reload ticks per slot) with
// the occupancy kept in flip-flops that reset clears at once. An add item
// (op = 1) stores its handle in the lowest free slot with delay_ms/TICK_MS+1
// ticks to go and a reload of period_ms/TICK_MS, and gives one result: task
// added, or table full. A tick item (op = 0) walks the slots in order, one
// memory read-modify-write per cycle while the output side does not stall it,
// counts down every occupied slot and gives one due result per slot that
// reaches zero, last set on the final one; a due slot reloads, or is freed
// when its reload is zero. The next item is taken while the last result still
// waits in the output register.
`include "periodic_task_timer_table_unit_assert.svh"

module periodic_task_timer_table_unit #(
    parameter int TASK_SLOTS = pttt_pkg::TASK_SLOTS_DEF,
    parameter int TICK_MS    = pttt_pkg::TICK_MS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [7:0]  i_task_handle,
    input  logic [15:0] i_delay_ms,
    input  logic [15:0] i_period_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_slot,
    output logic [7:0]  o_due_handle,
    output logic        o_last
);
    import pttt_pkg::*;

    localparam int          SW       = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(TASK_SLOTS - 1);
    localparam logic [31:0] RECIP    = 32'((64'd1 << 31) / TICK_MS);
    localparam logic [31:0] TICK_W   = 32'(TICK_MS);

    t_entry            mem [TASK_SLOTS];
    t_entry            r_rd_data;

    t_state            r_state, n_state;
    logic [SW-1:0]     r_idx, n_idx;
    logic [TASK_SLOTS-1:0] r_used, n_used;
    logic              r_pend_valid, n_pend_valid;
    logic              r_out_valid, n_out_valid;

    logic [7:0]        r_handle, n_handle;
    logic [15:0]       r_delay, n_delay;
    logic [15:0]       r_period, n_period;
    logic [15:0]       r_dly_q0, n_dly_q0;
    logic [15:0]       r_per_q0, n_per_q0;
    logic [15:0]       r_dly_q, n_dly_q;
    logic [15:0]       r_per_q, n_per_q;
    logic              r_found, n_found;
    logic [SW-1:0]     r_pend_slot, n_pend_slot;
    logic [7:0]        r_pend_handle, n_pend_handle;
    logic [1:0]        r_out_kind, n_out_kind;
    logic [2:0]        r_out_slot, n_out_slot;
    logic [7:0]        r_out_handle, n_out_handle;
    logic              r_out_last, n_out_last;

    logic              in_acc;
    logic              out_free;
    logic              w_en;
    logic [SW-1:0]     w_addr;
    t_entry            w_data;
    logic [SW-1:0]     rd_addr;
    logic              push;
    logic [1:0]        push_kind;
    logic [2:0]        push_slot;
    logic [7:0]        push_handle;
    logic              push_last;
    logic              advance;
    logic              walk_stall;
    logic [16:0]       dec;
    logic              due;
    logic              slot_used;
    logic [47:0]       dly_prod, per_prod;
    logic [31:0]       dly_rem, per_rem;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_slot      = r_out_slot;
    assign o_due_handle = r_out_handle;
    assign o_last      = r_out_last;
    assign walk_stall  = (r_state == S_T_EVAL) && !advance;

    assign dec       = r_rd_data.ticks - 17'd1;
    assign due       = (dec == 17'd0);
    assign slot_used = r_used[r_idx];

    // reciprocal estimate, then one correction step
    assign dly_prod = 48'(r_delay) * 48'(RECIP);
    assign per_prod = 48'(r_period) * 48'(RECIP);
    assign dly_rem  = 32'(r_delay) - (32'(r_dly_q0) * TICK_W);
    assign per_rem  = 32'(r_period) - (32'(r_per_q0) * TICK_W);

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_used        = r_used;
        n_pend_valid  = r_pend_valid;
        n_out_valid   = r_out_valid;
        n_handle      = r_handle;
        n_delay       = r_delay;
        n_period      = r_period;
        n_dly_q0      = r_dly_q0;
        n_per_q0      = r_per_q0;
        n_dly_q       = r_dly_q;
        n_per_q       = r_per_q;
        n_found       = r_found;
        n_pend_slot   = r_pend_slot;
        n_pend_handle = r_pend_handle;
        n_out_kind    = r_out_kind;
        n_out_slot    = r_out_slot;
        n_out_handle  = r_out_handle;
        n_out_last    = r_out_last;
        w_en          = 1'b0;
        w_addr        = r_idx;
        w_data        = r_rd_data;
        rd_addr       = r_idx;
        push          = 1'b0;
        push_kind     = KIND_DUE;
        push_slot     = 3'(r_pend_slot);
        push_handle   = r_pend_handle;
        push_last     = 1'b0;
        advance       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                rd_addr = '0;
                if (in_acc) begin
                    n_handle = i_task_handle;
                    n_delay  = i_delay_ms;
                    n_period = i_period_ms;
                    n_idx    = '0;
                    n_state  = i_op ? S_A_MUL : S_T_EVAL;
                end
            end
            S_A_MUL: begin
                n_dly_q0 = dly_prod[46:31];
                n_per_q0 = per_prod[46:31];
                n_state  = S_A_FIX;
            end
            S_A_FIX: begin
                n_dly_q = r_dly_q0 + {15'd0, (dly_rem >= TICK_W)};
                n_per_q = r_per_q0 + {15'd0, (per_rem >= TICK_W)};
                n_idx   = '0;
                n_state = S_A_SCAN;
            end
            S_A_SCAN: begin
                if (!slot_used) begin
                    n_found = 1'b1;
                    n_state = S_A_EMIT;
                end else if (r_idx == LAST_IDX) begin
                    n_found = 1'b0;
                    n_state = S_A_EMIT;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            S_A_EMIT: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    if (r_found) begin
                        push_kind     = KIND_ADDED;
                        push_slot     = 3'(r_idx);
                        push_handle   = r_handle;
                        w_en          = 1'b1;
                        w_data.handle = r_handle;
                        w_data.ticks  = 17'(r_dly_q) + 17'd1;
                        w_data.reload = r_per_q;
                        n_used[r_idx] = 1'b1;
                    end else begin
                        push_kind   = KIND_FULL;
                        push_slot   = 3'd0;
                        push_handle = 8'd0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_T_EVAL: begin
                if (!slot_used) begin
                    advance = 1'b1;
                end else if (!due) begin
                    w_en         = 1'b1;
                    w_data.ticks = dec;
                    advance      = 1'b1;
                end else if (!r_pend_valid || out_free) begin
                    // older due item goes out, this one waits to learn if it is last
                    push          = r_pend_valid;
                    n_pend_valid  = 1'b1;
                    n_pend_slot   = r_idx;
                    n_pend_handle = r_rd_data.handle;
                    if (r_rd_data.reload == 16'd0) begin
                        n_used[r_idx] = 1'b0;
                    end else begin
                        w_en         = 1'b1;
                        w_data.ticks = 17'(r_rd_data.reload);
                    end
                    advance = 1'b1;
                end
                if (advance) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = S_T_FLUSH;
                    end else begin
                        n_idx   = r_idx + SW'(1);
                        rd_addr = r_idx + SW'(1);
                    end
                end
            end
            S_T_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push         = 1'b1;
                    push_last    = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push) begin
            n_out_valid  = 1'b1;
            n_out_kind   = push_kind;
            n_out_slot   = push_slot;
            n_out_handle = push_handle;
            n_out_last   = push_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_used       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_used       <= n_used;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle      <= n_handle;
        r_delay       <= n_delay;
        r_period      <= n_period;
        r_dly_q0      <= n_dly_q0;
        r_per_q0      <= n_per_q0;
        r_dly_q       <= n_dly_q;
        r_per_q       <= n_per_q;
        r_found       <= n_found;
        r_pend_slot   <= n_pend_slot;
        r_pend_handle <= n_pend_handle;
        r_out_kind    <= n_out_kind;
        r_out_slot    <= n_out_slot;
        r_out_handle  <= n_out_handle;
        r_out_last    <= n_out_last;
    end

    `PTTT_ASSERT(a_idle_no_pending, o_in_ready |-> !r_pend_valid, "pending item at idle")
    `PTTT_ASSERT(a_add_is_last, o_out_valid && o_kind != KIND_DUE |-> o_last, "add not last")
    `PTTT_ASSERT(a_wr_state, w_en |-> (r_state == S_T_EVAL || r_state == S_A_EMIT), "stray write")
    `PTTT_ASSERT_NEXT(a_stall_holds, walk_stall, $stable({r_idx, r_state}), "walk moved")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import pttt_pkg::*;

    localparam int TASK_SLOTS    = TASK_SLOTS_DEF;
    localparam int TICK_MS       = TICK_MS_DEF;
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_ADD      = 1'b1;
    localparam int MAX_PERIODIC  = 4;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4 * TASK_SLOTS;

    typedef struct {
        t_kind      kind;
        logic [2:0] slot;
        logic [7:0] handle;
        logic       last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_op;
    logic [7:0]  i_task_handle;
    logic [15:0] i_delay_ms;
    logic [15:0] i_period_ms;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [2:0]  o_slot;
    logic [7:0]  o_due_handle;
    logic        o_last;

    t_result     pending_results[$];
    logic        tbl_used[TASK_SLOTS];
    logic [7:0]  tbl_handle[TASK_SLOTS];
    logic [16:0] tbl_ticks[TASK_SLOTS];
    logic [15:0] tbl_reload[TASK_SLOTS];

    int send_idle;
    int recv_idle;
    int fail_count = 0;
    int stall_cycles = 0;
    int n_adds;
    int n_ticks;
    int n_full;
    int n_checked = 0;
    int max_due;

    periodic_task_timer_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_task_handle (i_task_handle),
        .i_delay_ms    (i_delay_ms),
        .i_period_ms   (i_period_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_slot        (o_slot),
        .o_due_handle  (o_due_handle),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int expected_val, input int got_val);
        $display("ERROR @%0t: %s: expected %0d, got %0d", $realtime, what, expected_val, got_val);
        fail_count++;
    endtask

    task automatic timer_table_step(input logic op, input logic [7:0] handle,
                                    input logic [15:0] delay_ms, input logic [15:0] period_ms);
        int free_idx;
        int due;
        t_result r;
        free_idx = -1;
        due = 0;
        if (op == OP_ADD) begin
            n_adds++;
            for (int s = 0; s < TASK_SLOTS; s++) begin
                if (!tbl_used[s] && free_idx < 0) free_idx = s;
            end
            if (free_idx < 0) begin
                n_full++;
                r = '{kind: KIND_FULL, slot: 3'd0, handle: 8'd0, last: 1'b1};
            end else begin
                tbl_used[free_idx]   = 1'b1;
                tbl_handle[free_idx] = handle;
                tbl_ticks[free_idx]  = 17'(delay_ms / TICK_MS + 1);
                tbl_reload[free_idx] = 16'(period_ms / TICK_MS);
                r = '{kind: KIND_ADDED, slot: 3'(free_idx), handle: handle, last: 1'b1};
            end
            pending_results.push_back(r);
        end else begin
            n_ticks++;
            for (int s = 0; s < TASK_SLOTS; s++) begin
                if (tbl_used[s]) begin
                    tbl_ticks[s] = tbl_ticks[s] - 17'd1;
                    if (tbl_ticks[s] == 17'd0) begin
                        r = '{kind: KIND_DUE, slot: 3'(s), handle: tbl_handle[s], last: 1'b0};
                        pending_results.push_back(r);
                        due++;
                        if (tbl_reload[s] == 16'd0) begin
                            tbl_used[s]   = 1'b0;
                            tbl_handle[s] = 8'd0;
                            tbl_ticks[s]  = 17'd0;
                        end else begin
                            tbl_ticks[s] = 17'(tbl_reload[s]);
                        end
                    end
                end
            end
            if (due > 0) pending_results[pending_results.size() - 1].last = 1'b1;
            if (due > max_due) max_due = due;
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] handle,
                             input logic [15:0] delay_ms, input logic [15:0] period_ms);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_task_handle <= handle;
        i_delay_ms    <= delay_ms;
        i_period_ms   <= period_ms;
        do @(posedge i_clk); while (!o_in_ready);
        timer_table_step(op, handle, delay_ms, period_ms);
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, kind", -1, o_kind);
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (o_kind !== exp_r.kind) report_mismatch("kind", exp_r.kind, o_kind);
                if (o_slot !== exp_r.slot) report_mismatch("slot", exp_r.slot, o_slot);
                if (o_due_handle !== exp_r.handle)
                    report_mismatch("due_handle", exp_r.handle, o_due_handle);
                if (o_last !== exp_r.last) report_mismatch("last", exp_r.last, o_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_empty_tick;
        send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    endtask

    // eight one-shot tasks due on the first tick, then an add into a full table
    task automatic test_fill_and_overflow;
        logic [7:0] handles[TASK_SLOTS];
        handles = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
        for (int s = 0; s < TASK_SLOTS; s++)
            send_item(OP_ADD, handles[s], 16'(s % 2 == 0 ? 0 : 9), 16'(s));
        send_item(OP_ADD, 8'h42, 16'h0000, 16'h0000);
        send_item(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_periodic_reload;
        send_item(OP_ADD, 8'h3C, 16'd10, 16'd10);
        send_item(OP_ADD, 8'hC3, 16'd19, 16'd9);
        repeat (3) send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    endtask

    task automatic test_long_timer;
        send_item(OP_ADD, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_traffic(input int count, input int s_idle, input int r_idle);
        int periodic;
        logic [15:0] period;
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 50) begin
                send_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                periodic = 0;
                for (int s = 0; s < TASK_SLOTS; s++)
                    if (tbl_used[s] && tbl_reload[s] != 16'd0) periodic++;
                if (periodic < MAX_PERIODIC && $urandom_range(99) < 15)
                    period = 16'($urandom_range(10, 80));
                else
                    period = 16'($urandom_range(0, TICK_MS - 1));
                send_item(OP_ADD, 8'($urandom_range(255)), 16'($urandom_range(0, 60)), period);
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_op          <= OP_TICK;
        i_task_handle <= 8'h00;
        i_delay_ms    <= 16'h0000;
        i_period_ms   <= 16'h0000;
        send_idle    = 25;
        recv_idle    = 75;
        n_adds       = 0;
        n_ticks      = 0;
        n_full       = 0;
        max_due      = 0;
        for (int s = 0; s < TASK_SLOTS; s++) begin
            tbl_used[s]   = 1'b0;
            tbl_handle[s] = 8'd0;
            tbl_ticks[s]  = 17'd0;
            tbl_reload[s] = 16'd0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_tick;
        test_fill_and_overflow;
        test_periodic_reload;
        test_long_timer;
        test_random_traffic(65, 25, 75);
        wait_drained;
        test_random_traffic(65, 75, 25);
        wait_drained;
        test_random_traffic(65, 0, 0);
        wait_drained;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0)
            report_mismatch("results never delivered, count", 0, pending_results.size());
        $display("Covered %0d adds (%0d into a full table) and %0d ticks under three stall mixes",
                 n_adds, n_full, n_ticks);
        $display("Checked %0d results; largest burst of due tasks on one tick: %0d",
                 n_checked, max_due);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
